// File: rtl/tpw_pkg.sv
// Shared types, constants and arithmetic helpers of the tube preamp waveshaper.
// Used by every module under rtl/; depends on nothing.
package tpw_pkg;

  // Default parameter values
  localparam int RAMP_SAMPLES_DEF     = 960;
  localparam int NUM_CHANNELS_DEF     = 2;
  localparam int TANH_TABLE_DEPTH_DEF = 1024;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_GAIN       = 3'd1;
  localparam logic [2:0] REG_SHELF_NUM  = 3'd2;
  localparam logic [2:0] REG_SHELF_DEN  = 3'd3;
  localparam logic [2:0] REG_DC_GAIN    = 3'd4;
  localparam logic [2:0] REG_DC_DEN     = 3'd5;

  // Fixed-point constants, Q.23 unless noted
  localparam logic signed [31:0] ONE_Q23     = 32'sd8388608;
  localparam logic signed [31:0] C_POS_SLOPE = 32'sd838861;
  localparam logic signed [31:0] C_NEG_SLOPE = 32'sd419430;
  localparam logic signed [31:0] C_OUT_SCALE = 32'sd5872026;
  localparam logic signed [31:0] C_STAGE2    = 32'sd10066330;
  localparam logic signed [31:0] C_STAGE3    = 32'sd9227469;
  localparam logic signed [32:0] TANH_LIMIT  = 33'sd67108864;  // 8.0

  // Mode codes
  localparam logic [1:0] MODE_CLEAN = 2'd0;
  localparam logic [1:0] MODE_CRUNCH = 2'd1;
  localparam logic [1:0] MODE_HIGH  = 2'd2;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE, OP_SH_B0, OP_SH_Y, OP_SH_A1, OP_SH_S1, OP_SH_A2, OP_SH_S2,
    OP_GN_MUL, OP_GN_V, OP_T_IDX, OP_T_RD0, OP_T_RD1, OP_T_DIF, OP_T_INT,
    OP_P_M, OP_P_M2, OP_P_U, OP_P_U2, OP_P_O, OP_P_O2, OP_N_MUL, OP_N_ADD,
    OP_DC_B0, OP_DC_Y, OP_DC_A1, OP_DC_S1, OP_DC_S2
  } op_t;

  // Controller to datapath and ramp
  typedef struct packed {
    op_t        op;
    logic [1:0] stage;
    logic       load;
    logic       step;
  } cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic out_free;
    logic ramp_busy;
  } status_t;

  // Coefficients as the datapath sees them
  typedef struct packed {
    logic [1:0]         mode_eff;
    logic signed [19:0] sh_b0;
    logic signed [19:0] sh_b1;
    logic signed [19:0] sh_b2;
    logic signed [19:0] sh_a1;
    logic signed [19:0] sh_a2;
    logic signed [31:0] dc_b0;
    logic signed [31:0] dc_a1;
    logic signed [31:0] dc_a2;
  } coef_t;

  // Round to nearest, ties towards plus infinity
  function automatic logic signed [65:0] rnd(input logic signed [65:0] v,
                                             input logic [4:0] s);
    logic signed [65:0] half;
    half = 66'sd1 <<< (s - 5'd1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [65:0] v);
    if (v > 66'sd549755813887) return 40'sh7fffffffff;
    if (v < -66'sd549755813888) return 40'sh8000000000;
    return v[39:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    if (v > 32'sd8388607) return 24'sh7fffff;
    if (v < -32'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // Stage bias per mode, stages 0..2 scaled 1.0, 0.8, 0.6
  function automatic logic signed [31:0] bias(input logic [1:0] m,
                                              input logic [1:0] k);
    logic signed [31:0] b;
    case (k)
      2'd0:    b = 32'sd838861;
      2'd1:    b = 32'sd671089;
      default: b = 32'sd503316;
    endcase
    case (m)
      MODE_CLEAN:  return b;
      MODE_CRUNCH: return 32'sd0;
      default:     return -b;
    endcase
  endfunction

endpackage

// File: rtl/tpw_ramp.sv
// Gain ramp: current gain, per-item increment and a reciprocal divider for the step.
// Depends on tpw_pkg.
module tpw_ramp
  import tpw_pkg::*;
#(
  parameter int RAMP_SAMPLES = RAMP_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] target,
  input  logic        step,
  output logic [31:0] gain_now,
  output logic        busy
);

  localparam logic [15:0] RAMP  = RAMP_SAMPLES[15:0];
  // 2^48 / RAMP_SAMPLES; at most 49 bits
  localparam logic [48:0] RECIP = 49'((64'd1 << 48) / RAMP_SAMPLES);

  logic signed [33:0] gain_inc;
  logic [15:0]        ramp_left;
  logic [15:0]        tgt;
  logic [32:0]        mag;
  logic               neg;
  logic [2:0]         cnt;
  logic [81:0]        acc;
  logic signed [33:0] diff;
  logic [16:0]        pa;
  logic [24:0]        pb;
  logic [41:0]        pp;
  logic [81:0]        pp_sh;
  logic [32:0]        q_est;
  logic [48:0]        qd;
  logic [48:0]        rem;
  logic [32:0]        q_fix;

  assign diff  = $signed({2'b0, target, 16'b0}) - $signed({2'b0, gain_now});
  assign busy  = start || (cnt != 3'd0);

  // One partial product of magnitude and reciprocal a cycle, 17 by 25 bits
  assign pa    = cnt[1] ? {1'b0, mag[32:17]} : mag[16:0];
  assign pb    = cnt[0] ? RECIP[24:0] : {1'b0, RECIP[48:25]};
  assign pp    = pa * pb;

  always_comb begin
    case (cnt)
      3'd4:    pp_sh = {15'b0, pp, 25'b0};
      3'd3:    pp_sh = {23'b0, pp, 17'b0};
      3'd2:    pp_sh = {pp[39:0], 42'b0};
      default: pp_sh = {40'b0, pp};
    endcase
  end

  // Estimate is the quotient or one below it; one compare and subtract fixes it
  assign q_est = acc[80:48];
  assign qd    = 49'(q_est) * 49'(RAMP);
  assign rem   = {16'b0, mag} - qd;
  assign q_fix = (rem >= 49'(RAMP)) ? q_est + 33'd1 : q_est;

  // Restart the division on a write, accumulate the product, step per item
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_now  <= 32'h2800_0000;
      gain_inc  <= '0;
      ramp_left <= '0;
      tgt       <= 16'd10240;
      cnt       <= '0;
    end else if (start) begin
      neg       <= diff < 0;
      mag       <= diff < 0 ? 33'(-diff) : 33'(diff);
      acc       <= '0;
      tgt       <= target;
      cnt       <= 3'd5;
      ramp_left <= RAMP;
    end else if (cnt > 3'd1) begin
      acc <= acc + pp_sh;
      cnt <= cnt - 3'd1;
    end else if (cnt == 3'd1) begin
      gain_inc <= neg ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
      cnt      <= '0;
    end else if (step && ramp_left != 16'd0) begin
      ramp_left <= ramp_left - 16'd1;
      if (ramp_left == 16'd1) begin
        gain_now <= {tgt, 16'b0};
      end else begin
        gain_now <= gain_now + gain_inc[31:0];
      end
    end
  end

endmodule

// File: rtl/tpw_ctrl.sv
// Controller: sequences the micro-operations of one item through the datapath.
// Depends on tpw_pkg.
module tpw_ctrl
  import tpw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SH_B0, ST_SH_Y, ST_SH_A1, ST_SH_S1, ST_SH_A2, ST_SH_S2,
    ST_GN_MUL, ST_GN_V, ST_T_IDX, ST_T_RD0, ST_T_RD1, ST_T_DIF, ST_T_INT,
    ST_P_M, ST_P_M2, ST_P_U, ST_P_U2, ST_P_O, ST_P_O2, ST_N_MUL, ST_N_ADD,
    ST_DC_B0, ST_DC_Y, ST_DC_A1, ST_DC_S1, ST_DC_S2
  } state_t;

  state_t     state;
  logic [1:0] stage;
  logic       pass;

  assign in_ready = (state == ST_IDLE) && !status.ramp_busy;

  // Decode the state into a datapath operation
  always_comb begin
    cmd.stage = stage;
    cmd.load  = in_valid && in_ready;
    cmd.step  = state == ST_SH_S2;
    unique case (state)
      ST_IDLE:   cmd.op = OP_NONE;
      ST_SH_B0:  cmd.op = OP_SH_B0;
      ST_SH_Y:   cmd.op = OP_SH_Y;
      ST_SH_A1:  cmd.op = OP_SH_A1;
      ST_SH_S1:  cmd.op = OP_SH_S1;
      ST_SH_A2:  cmd.op = OP_SH_A2;
      ST_SH_S2:  cmd.op = OP_SH_S2;
      ST_GN_MUL: cmd.op = OP_GN_MUL;
      ST_GN_V:   cmd.op = OP_GN_V;
      ST_T_IDX:  cmd.op = OP_T_IDX;
      ST_T_RD0:  cmd.op = OP_T_RD0;
      ST_T_RD1:  cmd.op = OP_T_RD1;
      ST_T_DIF:  cmd.op = OP_T_DIF;
      ST_T_INT:  cmd.op = OP_T_INT;
      ST_P_M:    cmd.op = OP_P_M;
      ST_P_M2:   cmd.op = OP_P_M2;
      ST_P_U:    cmd.op = OP_P_U;
      ST_P_U2:   cmd.op = OP_P_U2;
      ST_P_O:    cmd.op = OP_P_O;
      ST_P_O2:   cmd.op = OP_P_O2;
      ST_N_MUL:  cmd.op = OP_N_MUL;
      ST_N_ADD:  cmd.op = OP_N_ADD;
      ST_DC_B0:  cmd.op = OP_DC_B0;
      ST_DC_Y:   cmd.op = OP_DC_Y;
      ST_DC_A1:  cmd.op = OP_DC_A1;
      ST_DC_S1:  cmd.op = OP_DC_S1;
      ST_DC_S2:  cmd.op = status.out_free ? OP_DC_S2 : OP_NONE;
      default:   cmd.op = OP_NONE;
    endcase
  end

  // Advance through shelf, gain, three shaper stages and DC blocker
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      stage <= '0;
      pass  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state <= ST_SH_B0;
            stage <= '0;
            pass  <= 1'b0;
          end
        end
        ST_SH_B0:  state <= ST_SH_Y;
        ST_SH_Y:   state <= ST_SH_A1;
        ST_SH_A1:  state <= ST_SH_S1;
        ST_SH_S1:  state <= ST_SH_A2;
        ST_SH_A2:  state <= ST_SH_S2;
        ST_SH_S2:  state <= ST_GN_MUL;
        ST_GN_MUL: state <= ST_GN_V;
        ST_GN_V:   state <= ST_T_IDX;
        ST_T_IDX:  state <= ST_T_RD0;
        ST_T_RD0:  state <= ST_T_RD1;
        ST_T_RD1:  state <= ST_T_DIF;
        ST_T_DIF:  state <= ST_T_INT;
        ST_T_INT:  state <= pass ? ST_P_O : ST_P_M;
        ST_P_M:    state <= ST_P_M2;
        ST_P_M2:   state <= ST_P_U;
        ST_P_U:    state <= ST_P_U2;
        ST_P_U2: begin
          state <= ST_T_IDX;
          pass  <= 1'b1;
        end
        ST_P_O:    state <= ST_P_O2;
        ST_P_O2: begin
          pass <= 1'b0;
          if (stage == 2'd2) begin
            state <= ST_DC_B0;
          end else begin
            state <= ST_N_MUL;
            stage <= stage + 2'd1;
          end
        end
        ST_N_MUL:  state <= ST_N_ADD;
        ST_N_ADD:  state <= ST_T_IDX;
        ST_DC_B0:  state <= ST_DC_Y;
        ST_DC_Y:   state <= ST_DC_A1;
        ST_DC_A1:  state <= ST_DC_S1;
        ST_DC_S1:  state <= ST_DC_S2;
        ST_DC_S2: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/tpw_datapath.sv
// Datapath: shared 32x32 multiplier, accumulator, tanh table, filter state
// and output register. Depends on tpw_pkg.
module tpw_datapath
  import tpw_pkg::*;
#(
  parameter int NUM_CHANNELS     = NUM_CHANNELS_DEF,
  parameter int TANH_TABLE_DEPTH = TANH_TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  coef_t              coef,
  input  logic [31:0]        gain_now,
  input  logic signed [23:0] in_sample,
  input  logic               in_channel,
  output logic signed [23:0] out_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_free
);

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int IDX_W = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int TAB_W = 24 * (TANH_TABLE_DEPTH + 1);
  localparam logic signed [31:0] DEPTH_S = 32'(TANH_TABLE_DEPTH);

  // Table step in Q.30 and tanh of one step by its series
  localparam longint unsigned TANH_H  = (64'd8 << 30) / TANH_TABLE_DEPTH;
  localparam longint unsigned TANH_H2 = (TANH_H * TANH_H) >> 30;
  localparam longint unsigned TANH_H3 = (TANH_H2 * TANH_H) >> 30;
  localparam longint unsigned TANH_H5 = (TANH_H3 * TANH_H2) >> 30;
  localparam longint unsigned TANH_H7 = (TANH_H5 * TANH_H2) >> 30;
  localparam longint unsigned TANH_H9 = (TANH_H7 * TANH_H2) >> 30;
  localparam longint unsigned TANH_TH = TANH_H - TANH_H3 / 3 + 2 * TANH_H5 / 15
                                        - 17 * TANH_H7 / 315 + 62 * TANH_H9 / 2835;

  // Tanh table over [0,8] by the addition formula, built at elaboration;
  // point k sits at bits 24*k
  function automatic logic [TAB_W-1:0] build_tab();
    logic [TAB_W-1:0] tab;
    longint unsigned  t, num, den, q, r;
    tab = '0;
    t   = 0;
    for (int i = 1; i <= TANH_TABLE_DEPTH; i++) begin
      num = (t + TANH_TH) << 30;
      den = (64'd1 << 30) + ((t * TANH_TH) >> 30);
      q   = 0;
      r   = 0;
      for (int b = 63; b >= 0; b--) begin
        r = {r[62:0], num[b]};
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 64'd1;
        end
      end
      t = q;
      tab[24*i +: 24] = 24'((t + 64) >> 7);
    end
    return tab;
  endfunction

  localparam logic [TAB_W-1:0] TANH_TAB = build_tab();
  localparam logic [23:0] ROM_TOP = TANH_TAB[24*TANH_TABLE_DEPTH +: 24];

  // Constant tanh table with a registered read port
  logic [23:0] rom_tab [0:TANH_TABLE_DEPTH];
  for (genvar g = 0; g <= TANH_TABLE_DEPTH; g++) begin : g_rom
    assign rom_tab[g] = TANH_TAB[24*g +: 24];
  end

  logic signed [31:0] sm0 [NUM_CHANNELS];
  logic signed [31:0] sm1 [NUM_CHANNELS];
  logic signed [39:0] dm0 [NUM_CHANNELS];
  logic signed [39:0] dm1 [NUM_CHANNELS];

  logic signed [23:0] xin;
  logic [CH_W-1:0]    ch;
  logic [CH_W-1:0]    ch_in;
  logic signed [31:0] wy, xs, v, tin, tout, mreg;
  logic signed [63:0] acc, prod, pb;
  logic [25:0]        frac;
  logic [IDX_W-1:0]   idx, rom_addr;
  logic [23:0]        rom_q, rom_lo;
  logic               big, neg;

  logic signed [31:0] mul_a, mul_b;
  logic               mul_en;
  logic signed [65:0] p66, acc66, pb66;
  logic signed [32:0] tin33, tabs;
  logic [25:0]        tclamp;
  logic signed [24:0] rdiff;
  logic signed [31:0] tv, v1, gn_x, n_x;
  logic [4:0]         gsh;

  assign p66   = 66'(prod);
  assign acc66 = 66'(acc);
  assign pb66  = 66'(pb);
  assign tin33 = 33'(tin);
  assign tabs  = tin33 < 0 ? -tin33 : tin33;
  assign tclamp = (tabs >= TANH_LIMIT) ? 26'h3ff_ffff : tabs[25:0];
  assign rdiff = $signed({1'b0, rom_q}) - $signed({1'b0, rom_lo});
  assign gsh   = 5'd20 - {3'b0, coef.mode_eff};
  assign v1    = sat32(rnd(p66, gsh));
  assign gn_x  = sat32(66'(v1) + 66'(bias(coef.mode_eff, 2'd0)));
  assign n_x   = sat32(rnd(p66, 5'd23) + 66'(bias(coef.mode_eff, cmd.stage)));
  assign tv    = big ? 32'({8'b0, ROM_TOP})
                     : 32'(66'($signed({1'b0, rom_lo})) + rnd(p66, 5'd26));
  assign out_free = !out_valid || out_ready;

  always_comb begin
    if (32'(in_channel) >= 32'(NUM_CHANNELS)) begin
      ch_in = CH_W'(NUM_CHANNELS - 1);
    end else begin
      ch_in = CH_W'(in_channel);
    end
  end

  // Select the multiplier operands for the current operation
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_SH_B0:  begin mul_a = 32'(xin); mul_b = 32'(coef.sh_b0); end
      OP_SH_Y:   begin mul_a = 32'(xin); mul_b = 32'(coef.sh_b1); end
      OP_SH_A1:  begin mul_a = wy; mul_b = 32'(coef.sh_a1); end
      OP_SH_S1:  begin mul_a = 32'(xin); mul_b = 32'(coef.sh_b2); end
      OP_SH_A2:  begin mul_a = wy; mul_b = 32'(coef.sh_a2); end
      OP_GN_MUL: begin mul_a = wy; mul_b = $signed({8'b0, gain_now[31:8]}); end
      OP_T_IDX:  begin mul_a = $signed({6'b0, tclamp}); mul_b = DEPTH_S; end
      OP_T_DIF:  begin mul_a = 32'(rdiff); mul_b = $signed({6'b0, frac}); end
      OP_P_M:    begin mul_a = xs; mul_b = (xs > 0) ? C_POS_SLOPE : C_NEG_SLOPE; end
      OP_P_U:    begin mul_a = tout; mul_b = mreg; end
      OP_P_O:    begin mul_a = tout; mul_b = C_OUT_SCALE; end
      OP_N_MUL:  begin mul_a = v; mul_b = (cmd.stage == 2'd1) ? C_STAGE2 : C_STAGE3; end
      OP_DC_B0:  begin mul_a = v; mul_b = coef.dc_b0; end
      OP_DC_A1:  begin mul_a = wy; mul_b = coef.dc_a1; end
      OP_DC_S1:  begin mul_a = wy; mul_b = coef.dc_a2; end
      default:   mul_en = 1'b0;
    endcase
  end

  // Table address: integer part of the scaled magnitude, then the next point
  always_comb begin
    case (cmd.op)
      OP_T_RD0: rom_addr = prod[26+IDX_W-1:26];
      OP_T_RD1: rom_addr = idx + IDX_W'(1);
      default:  rom_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    rom_q <= rom_tab[rom_addr];
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= 64'(mul_a * mul_b);
    end
    if (cmd.load) begin
      xin <= in_sample;
      ch  <= ch_in;
    end
    case (cmd.op)
      OP_SH_Y:  wy <= sat32(rnd(p66, 5'd17) + 66'(sm0[ch]));
      OP_SH_A1: acc <= prod;
      OP_SH_A2: acc <= prod;
      OP_GN_V: begin
        xs  <= gn_x;
        tin <= gn_x;
      end
      OP_T_IDX: begin
        big <= tabs >= TANH_LIMIT;
        neg <= tin < 0;
      end
      OP_T_RD0: begin
        idx  <= prod[26+IDX_W-1:26];
        frac <= prod[25:0];
      end
      OP_T_RD1: rom_lo <= rom_q;
      OP_T_INT: tout <= neg ? -tv : tv;
      OP_P_M2:  mreg <= 32'(66'(ONE_Q23) + rnd((xs > 0) ? p66 : -p66, 5'd23));
      OP_P_U2:  tin <= 32'(rnd(p66, 5'd23));
      OP_P_O2:  v <= 32'(rnd(p66, 5'd23));
      OP_N_ADD: begin
        xs  <= n_x;
        tin <= n_x;
      end
      OP_DC_Y: begin
        pb <= prod;
        wy <= sat32(rnd(rnd(p66, 5'd21) + 66'(dm0[ch]), 5'd8));
      end
      default: ;
    endcase
  end

  // Per-channel filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sm0[i] <= '0;
        sm1[i] <= '0;
        dm0[i] <= '0;
        dm1[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_SH_S1: sm0[ch] <= sat32(rnd(acc66 - p66, 5'd17) + 66'(sm1[ch]));
        OP_SH_S2: sm1[ch] <= sat32(rnd(acc66 - p66, 5'd17));
        OP_DC_S1: dm0[ch] <= sat40(rnd(-(pb66 <<< 1) - p66, 5'd21) + 66'(dm1[ch]));
        OP_DC_S2: dm1[ch] <= sat40(rnd(pb66 - p66, 5'd21));
        default: ;
      endcase
    end
  end

  // Output register: drop on handshake, load on the final operation
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == OP_DC_S2) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DC_S2) begin
      out_sample <= sat24(wy);
    end
  end

endmodule

// File: rtl/tube_preamp_waveshaper_core.sv
// Top level of the tube preamp waveshaper: configuration registers and APB port,
// controller, datapath and gain ramp. Depends on tpw_pkg and the tpw_* modules.
//
//  channel   signals                          item
//  --------  -------------------------------  ---------------------------------
//  s_ (in)   s_tvalid s_tready s_tdata s_tuser  sample_in, channel
//  m_ (out)  m_tvalid m_tready m_tdata          sample_out
//  config    psel penable pwrite paddr pwdata   six registers at 8*index
//
// Each item is finished before the next one is accepted: one
// shared 32x32 multiplier runs the shelf, gain, six table lookups with their
// shaper arithmetic and the DC blocker in turn. A write of gain_target holds
// s_tready low, from the access cycle on, while the ramp step is formed by a reciprocal
// multiplication and one correction. Reset is synchronous; it clears the filter state
// and loads the register defaults. The finished sample waits in an output register,
// and the next item is worked on until that register is needed.
module tube_preamp_waveshaper_core
  import tpw_pkg::*;
#(
  parameter int RAMP_SAMPLES     = RAMP_SAMPLES_DEF,
  parameter int NUM_CHANNELS     = NUM_CHANNELS_DEF,
  parameter int TANH_TABLE_DEPTH = TANH_TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] sample_in
  input  logic [0:0]  s_tuser,   // [0] channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [23:0] sample_out
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [1:0]  mode;
  logic [15:0] gain_target;
  logic [59:0] shelf_num;
  logic [39:0] shelf_den;
  logic [31:0] dc_gain;
  logic [63:0] dc_den;

  logic        wr;
  logic [2:0]  reg_idx;
  logic        gain_wr;
  logic [31:0] gain_now;
  status_t     status;
  cmd_t        cmd;
  coef_t       coef;
  logic        ramp_busy;
  logic        out_free;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];
  assign gain_wr = wr && (reg_idx == REG_GAIN);

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_CRUNCH;
      gain_target <= 16'd10240;
      shelf_num   <= 60'd131072;
      shelf_den   <= '0;
      dc_gain     <= '0;
      dc_den      <= '0;
    end else if (wr) begin
      unique case (reg_idx)
        REG_MODE:      mode        <= pwdata[1:0];
        REG_GAIN:      gain_target <= pwdata[15:0];
        REG_SHELF_NUM: shelf_num   <= pwdata[59:0];
        REG_SHELF_DEN: shelf_den   <= pwdata[39:0];
        REG_DC_GAIN:   dc_gain     <= pwdata[31:0];
        REG_DC_DEN:    dc_den      <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_MODE:      prdata = 64'(mode);
      REG_GAIN:      prdata = 64'(gain_target);
      REG_SHELF_NUM: prdata = 64'(shelf_num);
      REG_SHELF_DEN: prdata = 64'(shelf_den);
      REG_DC_GAIN:   prdata = 64'(dc_gain);
      REG_DC_DEN:    prdata = dc_den;
      default:       prdata = '0;
    endcase
  end

  // Unpack coefficients; mode three acts as high gain
  always_comb begin
    coef.mode_eff = (mode == 2'd3) ? MODE_HIGH : mode;
    coef.sh_b0    = shelf_num[19:0];
    coef.sh_b1    = shelf_num[39:20];
    coef.sh_b2    = shelf_num[59:40];
    coef.sh_a1    = shelf_den[19:0];
    coef.sh_a2    = shelf_den[39:20];
    coef.dc_b0    = dc_gain;
    coef.dc_a1    = dc_den[31:0];
    coef.dc_a2    = dc_den[63:32];
  end

  assign status.out_free  = out_free;
  assign status.ramp_busy = ramp_busy;

  tpw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tpw_ramp #(
    .RAMP_SAMPLES (RAMP_SAMPLES)
  ) u_ramp (
    .clk      (clk),
    .rst      (rst),
    .start    (gain_wr),
    .target   (pwdata[15:0]),
    .step     (cmd.step),
    .gain_now (gain_now),
    .busy     (ramp_busy)
  );

  tpw_datapath #(
    .NUM_CHANNELS     (NUM_CHANNELS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .coef       (coef),
    .gain_now   (gain_now),
    .in_sample  (s_tdata),
    .in_channel (s_tuser[0]),
    .out_sample (m_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_free   (out_free)
  );

  // No item enters while the ramp step is being divided
  a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (rst)
    ramp_busy |-> !s_tready)
    else $error("item accepted during ramp division");

  // One item at a time: the cycle after an accept the input is closed
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while one is in flight");

  // A gain write starts the divider
  a_gain_write_starts_ramp: assert property (@(posedge clk) disable iff (rst)
    gain_wr |=> ramp_busy)
    else $error("gain write did not start the ramp divider");

endmodule
